@@ sv/battery_level_indicator_top_macros.svh @@
// Assertion helpers for the top module, which checks its own logic.
`ifndef BATTERY_LEVEL_INDICATOR_TOP_MACROS_SVH
`define BATTERY_LEVEL_INDICATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BLI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("battery level indicator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("battery level indicator check failed");

`endif

@@ sv/bli_pkg.sv @@
package bli_pkg;

  // Field widths.
  localparam int unsigned AdcW   = 11;
  localparam int unsigned IndW   = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned LevelW = 16;
  localparam int unsigned DigitW = 4;
  localparam int unsigned OperW  = 16;
  localparam int unsigned CoefW  = 10;
  localparam int unsigned AccW   = 21;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Linear level scale: the ADC window from empty to full maps onto 0..65535.
  localparam int unsigned FullAdc  = 'h370;
  localparam int unsigned EmptyAdc = 'h300;
  localparam int unsigned SpanAdc  = FullAdc - EmptyAdc;
  localparam logic [CoefW-1:0] Slope  = CoefW'(65536 / SpanAdc);
  localparam logic [AccW-1:0]  Offset = AccW'((EmptyAdc * 65536) / SpanAdc);
  localparam logic [CoefW-1:0] Ten    = CoefW'(10);
  localparam logic [OperW-1:0] HalfUnit = OperW'(32768);
  localparam logic [LevelW-1:0] LevelMax = '1;

  // Indicator codes.
  localparam logic [IndW-1:0] IndOff  = 4'h0;
  localparam logic [IndW-1:0] IndOn   = 4'hF;
  localparam logic [IndW-1:0] IndPlug = 4'h8;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgCritical = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLow      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPlugged  = 2'd2;
  localparam logic [AdcW-1:0] CriticalRst = 11'd773;
  localparam logic [AdcW-1:0] LowRst      = 11'd779;
  localparam logic [AdcW-1:0] PluggedRst  = 11'd1024;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CLAMP,
    ST_TENS,
    ST_ONES,
    ST_DONE
  } bli_state_e;

  // One request to the shared multiply-add unit: acc = a * b + c.
  typedef struct packed {
    logic             en;
    logic [OperW-1:0] a;
    logic [CoefW-1:0] b;
    logic [OperW-1:0] c;
  } bli_mul_req_t;

endpackage

@@ sv/battery_level_indicator_top.sv @@
// Battery level indicator.
// Input stream (s_axis_*): one beat per battery ADC reading with the CPU
// fast-mode flag. Output stream (m_axis_*): exactly one result beat per
// input beat, in order, carrying the indicator, slow-lock, redraw flag and,
// on every eighth counted reading, the charging flag or percentage digits.
// Configuration: cfg_we_i writes cfg_data_i to the threshold register at
// cfg_idx_i (0 critical, 1 low, 2 plugged code); write only while idle.
// Sequencing: a reading without a level update passes through the done
// state to the result register. A level update runs the scale, clamp,
// tens, ones and done states; one shared multiply-add unit runs three
// times (scale, tens digit, ones digit), with a clamp step between the
// first two. The input is not ready while a reading is in work.
// A finished result waits in the output register; the next reading can be
// accepted meanwhile, but its result stalls until the receiver takes the
// waiting beat. Reset clears the indicator, slow-lock, read counter and
// output valid, and loads the threshold reset values.
module battery_level_indicator_top import bli_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [AdcW-1:0]       cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: adc_reading[10:0], cpu_fast_mode[11], zero pad.
  input  logic [InDataW-1:0]    s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: indicator[3:0], slow_lock[4], screen_refresh[5],
  // level_update[6], charging[7], scaled_level[23:8], hundreds_digit[24],
  // tens_shown[25], tens_digit[29:26], ones_digit[33:30], zero pad.
  output logic [OutDataW-1:0]   m_axis_tdata
);

  bli_state_e state_q, state_d;

  logic [AdcW-1:0]   crit_q, low_q, plug_q;
  logic [IndW-1:0]   ind_q, ind_d;
  logic              lock_q, lock_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              refresh_q, refresh_d;
  logic              upd_q, upd_d;
  logic              chg_q;
  logic [AdcW-1:0]   adc_q;
  logic [LevelW-1:0] level_q, level_d;
  logic              hund_q;
  logic [DigitW-1:0] tens_q;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  bli_mul_req_t      mul_req;
  logic [AccW-1:0]   acc;
  logic [LevelW:0]   level_inc;
  logic [AccW-1:0]   acc_off;
  logic              digits_on;
  logic              shown;

  logic [AdcW-1:0]   rd;
  logic              fast;
  logic              below_crit, below_low, is_plug, skip;

  assign rd       = s_axis_tdata[AdcW-1:0];
  assign fast     = s_axis_tdata[AdcW];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= CriticalRst;
      low_q  <= LowRst;
      plug_q <= PluggedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCritical: crit_q <= cfg_data_i;
        CfgLow:      low_q  <= cfg_data_i;
        CfgPlugged:  plug_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Indicator rules applied to the incoming reading.
  always_comb begin
    below_crit = rd < crit_q;
    below_low  = rd < low_q;
    is_plug    = rd == plug_q;
    skip       = !below_crit && below_low && fast;
    ind_d      = ind_q;
    lock_d     = lock_q;
    refresh_d  = 1'b0;
    cnt_d      = cnt_q;
    upd_d      = 1'b0;
    if (below_crit) begin
      ind_d     = ind_q ^ IndOn;
      lock_d    = 1'b1;
      refresh_d = 1'b1;
    end else if (below_low && !fast) begin
      refresh_d = ind_q == IndOff;
      ind_d     = IndOn;
      lock_d    = 1'b1;
    end
    if (!skip) begin
      if (is_plug) begin
        refresh_d = refresh_d || (ind_d == IndOff);
        ind_d     = IndPlug;
        lock_d    = 1'b0;
      end else if (!below_low) begin
        refresh_d = refresh_d || (ind_d != IndOff);
        ind_d     = IndOff;
        lock_d    = 1'b0;
      end
      cnt_d = cnt_q + CntW'(1);
      upd_d = cnt_d == '0;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = upd_d ? ST_SCALE : ST_DONE;
        end
      end
      ST_SCALE: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_TENS;
      ST_TENS:  state_d = ST_ONES;
      ST_ONES:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and the request to the multiply-add unit.
  assign level_inc = {1'b0, level_q} + (LevelW + 1)'(1);

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mul_req       = '0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SCALE: begin
        mul_req.en = 1'b1;
        mul_req.a  = OperW'(adc_q);
        mul_req.b  = Slope;
      end
      ST_CLAMP: ;
      ST_TENS: begin
        mul_req.en = 1'b1;
        mul_req.a  = level_inc[LevelW] ? '0 : level_inc[LevelW-1:0];
        mul_req.b  = Ten;
      end
      ST_ONES: begin
        mul_req.en = 1'b1;
        mul_req.a  = acc[OperW-1:0];
        mul_req.b  = Ten;
        mul_req.c  = HalfUnit;
      end
      ST_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  bli_mul_unit u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .acc_o (acc)
  );

  // Clamp the scaled reading to the 16-bit level range.
  assign acc_off = acc - Offset;

  always_comb begin
    if (acc < Offset) begin
      level_d = '0;
    end else if (acc_off > AccW'(LevelMax)) begin
      level_d = LevelMax;
    end else begin
      level_d = acc_off[LevelW-1:0];
    end
  end

  // Persistent indicator state, updated when a reading is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ind_q  <= IndOff;
      lock_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_fire) begin
      ind_q  <= ind_d;
      lock_q <= lock_d;
      cnt_q  <= cnt_d;
    end
  end

  // Per-reading working registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      adc_q     <= rd;
      refresh_q <= refresh_d;
      upd_q     <= upd_d;
      chg_q     <= upd_d && is_plug;
      level_q   <= '0;
    end
    if (state_q == ST_CLAMP) begin
      level_q <= level_d;
    end
    if (state_q == ST_TENS) begin
      hund_q <= level_inc[LevelW];
    end
    if (state_q == ST_ONES) begin
      tens_q <= acc[OperW+DigitW-1:OperW];
    end
  end

  // Result beat assembly; digits only on a non-charging level update.
  assign digits_on = upd_q && !chg_q;
  assign shown     = hund_q || (tens_q != '0);

  always_comb begin
    m_data_d        = '0;
    m_data_d[3:0]   = ind_q;
    m_data_d[4]     = lock_q;
    m_data_d[5]     = refresh_q;
    m_data_d[6]     = upd_q;
    m_data_d[7]     = chg_q;
    m_data_d[23:8]  = level_q;
    if (digits_on) begin
      m_data_d[24]    = hund_q;
      m_data_d[25]    = shown;
      m_data_d[29:26] = tens_q;
      m_data_d[33:30] = acc[OperW+DigitW-1:OperW];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "battery_level_indicator_top_macros.svh"

  // An accepted reading keeps the input closed on the next cycle.
  `BLI_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready)
  // Charging is only reported together with a level update.
  `BLI_ASSERT_NOW(a_chg_needs_upd, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[6])
  // Without a level update every level field is zero.
  `BLI_ASSERT_NOW(a_no_upd_zero, m_axis_tvalid && !m_axis_tdata[6],
                  m_axis_tdata[33:8] == '0)
  // The rounded ones digit never exceeds ten.
  `BLI_ASSERT_NOW(a_ones_range, m_axis_tvalid, m_axis_tdata[33:30] <= 4'd10)

endmodule

@@ sv/bli_mul_unit.sv @@
module bli_mul_unit import bli_pkg::*; (
  input  logic                clk_i,
  input  bli_mul_req_t        req_i,
  output logic [AccW-1:0]     acc_o
);

  logic [OperW+CoefW-1:0] mult;
  logic [OperW+CoefW:0]   prod;
  logic [AccW-1:0]        acc_q;

  // Full-width product of the operand and the small coefficient.
  assign mult = (OperW + CoefW)'(req_i.a) * (OperW + CoefW)'(req_i.b);

  // Multiply by a small coefficient and add a rounding term.
  assign prod = {1'b0, mult} + (OperW + CoefW + 1)'(req_i.c);

  // All operands keep the result below 2^21, so the top bits are dropped.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= prod[AccW-1:0];
    end
  end

  assign acc_o = acc_q;

endmodule
